/* design/assert_macros.svh */
// Assertion macros shared by the redactor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check that is switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
// Clocked check that also runs during reset.
`define ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

/* design/kvr_pkg.sv */
`timescale 1ns / 1ps
// Types, character constants and keyword tables for the keyword/value redactor.
package kvr_pkg;

  localparam logic [7:0] FILL_RESET = 8'h58;  // 'X'

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_MATCH = 2'd1,
    PH_VALUE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    SEP_BSLASH = 2'd0,
    SEP_BAR    = 2'd1,
    SEP_DOT    = 2'd2,
    SEP_NONE   = 2'd3
  } sep_t;

  typedef enum logic [2:0] {
    KW_SAMPLEID = 3'd0,
    KW_FILENAME = 3'd1,
    KW_ORIGGUID = 3'd2,
    KW_GUID     = 3'd3,
    KW_FIL      = 3'd4
  } kw_t;

  typedef struct packed {
    phase_t     phase;
    sep_t       open_sep;
    kw_t        kw;
    logic [3:0] match_pos;
  } match_state_t;

  localparam match_state_t MATCH_RESET = '{
    phase: PH_IDLE, open_sep: SEP_BSLASH, kw: KW_SAMPLEID, match_pos: 4'd0
  };

  // Keyword texts, padded with zero bytes to sixteen characters.
  localparam logic [7:0] SAMPLEID_TXT [16] = '{
    "@", "S", "A", "M", "P", "L", "E", "I", "D", "1",
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };
  localparam logic [7:0] FILENAME_TXT [16] = '{
    "F", "I", "L", "E", "N", "A", "M", "E",
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };
  localparam logic [7:0] ORIGGUID_TXT [16] = '{
    "O", "R", "I", "G", "I", "N", "A", "L", "G", "U", "I", "D",
    8'h00, 8'h00, 8'h00, 8'h00
  };
  localparam logic [7:0] GUID_TXT [16] = '{
    "G", "U", "I", "D",
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00
  };
  localparam logic [7:0] FIL_TXT [16] = '{
    "$", "F", "I", "L",
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00
  };

  function automatic sep_t sep_code(input logic [7:0] b);
    sep_t sc;
    unique case (b)
      CH_BSLASH: sc = SEP_BSLASH;
      CH_BAR:    sc = SEP_BAR;
      CH_DOT:    sc = SEP_DOT;
      default:   sc = SEP_NONE;
    endcase
    return sc;
  endfunction

  function automatic logic [3:0] kw_len(input kw_t kw);
    logic [3:0] len;
    unique case (kw)
      KW_SAMPLEID: len = 4'd10;
      KW_FILENAME: len = 4'd8;
      KW_ORIGGUID: len = 4'd12;
      KW_GUID:     len = 4'd4;
      KW_FIL:      len = 4'd4;
      default:     len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] kw_char(input kw_t kw, input logic [3:0] pos);
    logic [7:0] ch;
    unique case (kw)
      KW_SAMPLEID: ch = SAMPLEID_TXT[pos];
      KW_FILENAME: ch = FILENAME_TXT[pos];
      KW_ORIGGUID: ch = ORIGGUID_TXT[pos];
      KW_GUID:     ch = GUID_TXT[pos];
      KW_FIL:      ch = FIL_TXT[pos];
      default:     ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* design/kvr_matcher.sv */
`timescale 1ns / 1ps
// Keyword matcher: next matcher state and the output byte for one stream word.
module kvr_matcher import kvr_pkg::*; (
  input  match_state_t state_cur,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  input  logic [7:0]   fill_byte,
  output match_state_t state_nxt,
  output logic [7:0]   res_byte,
  output logic         res_redacted
);

  sep_t         sc;
  match_state_t restart;
  logic         redact;

  assign sc = sep_code(data_byte);

  // A separator opens a fresh keyword match; anything else drops back to idle.
  always_comb begin
    restart           = state_cur;
    restart.match_pos = 4'd0;
    restart.kw        = KW_SAMPLEID;
    if (sc != SEP_NONE) begin
      restart.phase    = PH_MATCH;
      restart.open_sep = sc;
    end else begin
      restart.phase = PH_IDLE;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_cur;
    unique case (state_cur.phase)
      PH_MATCH: begin
        if (state_cur.kw > KW_FIL) begin
          state_nxt = restart;
        end else if (state_cur.match_pos == 4'd0) begin
          state_nxt.match_pos = 4'd1;
          case (data_byte)
            SAMPLEID_TXT[0]: state_nxt.kw = KW_SAMPLEID;
            FILENAME_TXT[0]: state_nxt.kw = KW_FILENAME;
            ORIGGUID_TXT[0]: state_nxt.kw = KW_ORIGGUID;
            GUID_TXT[0]:     state_nxt.kw = KW_GUID;
            FIL_TXT[0]:      state_nxt.kw = KW_FIL;
            default:         state_nxt    = restart;
          endcase
        end else if (state_cur.match_pos < kw_len(state_cur.kw)) begin
          if (kw_char(state_cur.kw, state_cur.match_pos) == data_byte) begin
            state_nxt.match_pos = state_cur.match_pos + 4'd1;
          end else begin
            state_nxt = restart;
          end
        end else if (sc == state_cur.open_sep) begin
          state_nxt.phase     = PH_VALUE;
          state_nxt.match_pos = 4'd0;
        end else begin
          state_nxt = restart;
        end
      end
      PH_VALUE: begin
        if (sc == state_cur.open_sep) begin
          state_nxt = restart;
        end
      end
      default: state_nxt = restart;
    endcase
    if (last_byte) begin
      state_nxt = MATCH_RESET;
    end
  end

  // Outputs: every byte inside a value, up to the closing separator, is filled.
  always_comb begin
    redact = (state_cur.phase == PH_VALUE) && (sc != state_cur.open_sep);
    res_redacted = redact;
    res_byte     = redact ? fill_byte : data_byte;
  end

endmodule

/* design/keyword_value_redactor.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Top level of the keyword/value redactor.
//
// Input channel: in_valid/in_ready carry one text byte per word plus a flag
// marking the final byte of a stream. Output channel: out_valid/out_ready
// return exactly one word per input word, in order, with the byte either
// passed through or replaced by the fill byte, a redaction flag and the copy
// of the end-of-stream flag. The cfg channel writes the fill byte; it is
// always ready and should only be written while no words are in flight.
// An accepted word waits in the input register, passes the combinational
// matcher update between the two registers and waits in the output register
// until taken. Throughput is one word per cycle while out_ready stays high.
// When the receiver stalls, the output register holds its word and the
// input register takes one more word before in_ready drops.
// Synchronous reset empties both registers, returns the matcher to idle and
// sets the fill byte to 'X'. The end-of-stream flag also returns the matcher
// to idle after its word is processed.
module keyword_value_redactor import kvr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_was_redacted,
  output logic       out_last_out,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic         s1_valid_r, s1_valid_nxt;
  logic [7:0]   s1_data_r;
  logic         s1_last_r;
  logic         out_valid_r, out_valid_nxt;
  logic [7:0]   out_byte_r;
  logic         out_redacted_r;
  logic         out_last_r;
  logic [7:0]   fill_byte_r, fill_byte_nxt;
  match_state_t state_r, state_nxt;
  match_state_t match_nxt;
  logic [7:0]   res_byte;
  logic         res_redacted;
  logic         advance;
  logic         in_take;

  kvr_matcher u_matcher (
    .state_cur    (state_r),
    .data_byte    (s1_data_r),
    .last_byte    (s1_last_r),
    .fill_byte    (fill_byte_r),
    .state_nxt    (match_nxt),
    .res_byte     (res_byte),
    .res_redacted (res_redacted)
  );

  // The held word moves on when the output register is empty or being drained.
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    state_nxt     = advance ? match_nxt : state_r;
    fill_byte_nxt = (cfg_valid && cfg_ready) ? cfg_data : fill_byte_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= MATCH_RESET;
      fill_byte_r <= FILL_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
      fill_byte_r <= fill_byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (advance) begin
      out_byte_r     <= res_byte;
      out_redacted_r <= res_redacted;
      out_last_r     <= s1_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_was_redacted = out_redacted_r;
  assign out_last_out     = out_last_r;

  `ASSERT_RST(a_reset_empty, clk, !rst_n |=> !s1_valid_r && !out_valid_r, "registers not empty after reset")
  `ASSERT_CLK(a_last_idles, clk, rst_n, advance && s1_last_r |=> state_r == MATCH_RESET, "matcher not idle after last byte")
  `ASSERT_CLK(a_match_bound, clk, rst_n, state_r.phase == PH_MATCH |-> state_r.kw <= KW_FIL && state_r.match_pos <= kw_len(state_r.kw), "keyword position out of range")
  `ASSERT_CLK(a_no_lost_word, clk, rst_n, out_valid_r && !out_ready |=> out_valid_r, "pending result dropped")

endmodule
